// ----- sv/advanced_timer_with_compare_top_assert.svh -----
// Assertion macros used by the checker file.
`ifndef ADVANCED_TIMER_WITH_COMPARE_TOP_ASSERT_SVH
`define ADVANCED_TIMER_WITH_COMPARE_TOP_ASSERT_SVH

// Property checked on every rising clk edge outside reset.
`define ATWC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define ATWC_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ----- sv/atwc_pkg.sv -----
package atwc_pkg;

    localparam int COUNTER_WIDTH = 16;
    localparam int CHANNELS      = 4;

    localparam int OP_W       = 2;
    localparam int OFS_W      = 10;
    localparam int DATA_W     = 32;
    localparam int IRQ_W      = 31;
    localparam int PSC_W      = 16;
    localparam int PSC_CNT_W  = 17;
    localparam int REP_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;
    localparam int SLOT_W     = 3;

    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CORE_FAMILY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_SLOT  = 1'b1;

    localparam logic [OFS_W-1:0] OFS_CR1   = 10'h000;
    localparam logic [OFS_W-1:0] OFS_CR2   = 10'h004;
    localparam logic [OFS_W-1:0] OFS_SMCR  = 10'h008;
    localparam logic [OFS_W-1:0] OFS_DIER  = 10'h00C;
    localparam logic [OFS_W-1:0] OFS_SR    = 10'h010;
    localparam logic [OFS_W-1:0] OFS_EGR   = 10'h014;
    localparam logic [OFS_W-1:0] OFS_CCMR0 = 10'h018;
    localparam logic [OFS_W-1:0] OFS_CCMR1 = 10'h01C;
    localparam logic [OFS_W-1:0] OFS_CCER  = 10'h020;
    localparam logic [OFS_W-1:0] OFS_CNT   = 10'h024;
    localparam logic [OFS_W-1:0] OFS_PSC   = 10'h028;
    localparam logic [OFS_W-1:0] OFS_ARR   = 10'h02C;
    localparam logic [OFS_W-1:0] OFS_RCR   = 10'h030;
    localparam logic [OFS_W-1:0] OFS_CCR0  = 10'h034;
    localparam logic [OFS_W-1:0] OFS_BDTR  = 10'h044;
    localparam int               CCR_STRIDE = 4;

    // Status flag positions
    localparam int FLAG_UPDATE = 0;
    localparam int FLAG_COM    = 5;

    localparam logic [DATA_W-1:0] CHAN_FLAG_MASK =
        DATA_W'(((64'd1 << CHANNELS) - 64'd1) << 1);
    localparam logic [DATA_W-1:0] TRG_BRK_MASK  = 32'h0000_00C0;
    localparam logic [DATA_W-1:0] CC_GROUP_MASK = 32'h0000_001E;
    localparam logic [DATA_W-1:0] UP_GROUP_MASK = 32'h0000_00E1;

    // Interrupt controller line numbers
    localparam int IRQ_HI_UPDATE = 25;
    localparam int IRQ_HI_CC     = 27;
    localparam int IRQ_HI_SLOT1  = 29;
    localparam int IRQ_HI_SLOT3  = 28;
    localparam int IRQ_HI_SLOT4  = 30;
    localparam int IRQ_LO_UPDATE = 13;
    localparam int IRQ_LO_CC     = 14;
    localparam int IRQ_LO_SLOT1  = 16;
    localparam int IRQ_LO_SLOT5  = 19;
    localparam int IRQ_LO_SLOT2  = 20;

    typedef logic [COUNTER_WIDTH-1:0] cnt_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [OFS_W-1:0]  reg_offset;
        logic [DATA_W-1:0] write_data;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [IRQ_W-1:0]  irq_raise;
    } result_t;

    function automatic logic [IRQ_W-1:0] irq_map(
        input logic              family,
        input logic [SLOT_W-1:0] slot,
        input logic [DATA_W-1:0] pend
    );
        logic [IRQ_W-1:0] lines;
        lines = '0;
        if (pend != '0)
        begin
            if (family)
            begin
                case (slot)
                    3'd0:
                    begin
                        lines[IRQ_HI_UPDATE] = pend[FLAG_UPDATE];
                        lines[IRQ_HI_CC]     = |(pend & CC_GROUP_MASK);
                    end
                    3'd1:    lines[IRQ_HI_SLOT1] = 1'b1;
                    3'd3:    lines[IRQ_HI_SLOT3] = 1'b1;
                    3'd4:    lines[IRQ_HI_SLOT4] = 1'b1;
                    default: lines = '0;
                endcase
            end
            else
            begin
                case (slot)
                    3'd0:
                    begin
                        lines[IRQ_LO_UPDATE] = |(pend & UP_GROUP_MASK);
                        lines[IRQ_LO_CC]     = |(pend & CC_GROUP_MASK);
                    end
                    3'd1:    lines[IRQ_LO_SLOT1] = 1'b1;
                    3'd5:    lines[IRQ_LO_SLOT5] = 1'b1;
                    3'd2:    lines[IRQ_LO_SLOT2] = 1'b1;
                    default: lines = '0;
                endcase
            end
        end
        return lines;
    endfunction

endpackage

// ----- sv/atwc_if.sv -----
interface atwc_in_if;
    logic                          valid;
    logic                          ready;
    logic [atwc_pkg::OP_W-1:0]     operation;
    logic [atwc_pkg::OFS_W-1:0]    reg_offset;
    logic [atwc_pkg::DATA_W-1:0]   write_data;

    modport source (output valid, output operation, output reg_offset,
                    output write_data, input ready);
    modport sink   (input valid, input operation, input reg_offset,
                    input write_data, output ready);
endinterface

interface atwc_out_if;
    logic                          valid;
    logic                          ready;
    logic [atwc_pkg::DATA_W-1:0]   read_data;
    logic [atwc_pkg::IRQ_W-1:0]    irq_raise;

    modport source (output valid, output read_data, output irq_raise,
                    input ready);
    modport sink   (input valid, input read_data, input irq_raise,
                    output ready);
endinterface

// ----- sv/advanced_timer_with_compare_top.sv -----
// Advanced-control timer with four compare channels.
// in_ch carries one item per transfer: a register read, a register write
// or one input clock tick (operation, reg_offset, write_data).
// out_ch returns exactly one result per item, in order: read_data holds the
// register on a read (zero otherwise or when unmapped), irq_raise the
// interrupt controller lines raised by a tick.
// cfg_we/cfg_index/cfg_data set core_family (index 0) and timer_slot
// (index 1); write them only while no item is in flight.
// Pipeline: the input register captures an item at its transfer and the
// timer step writes the state and the result register once the output
// can advance, so each result passes the input register, then the result
// register. Throughput: one item per cycle while out_ch is not stalled; the
// whole timer step is one pass of logic between those two registers.
// Reset: all timer registers clear to zero, core_family returns to 1,
// timer_slot to 0, and both pipeline registers empty.
// Output stall: the result register holds; one more item is taken into
// the input register, after which in_ch.ready drops until out_ch moves.
module advanced_timer_with_compare_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    atwc_in_if.sink                           in_ch,
    atwc_out_if.source                        out_ch,
    input  logic                              cfg_we,
    input  logic [atwc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [atwc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic              in_valid_reg;
    logic              out_valid_reg;
    atwc_pkg::item_t   item_reg;
    atwc_pkg::result_t result_reg;
    atwc_pkg::result_t result_next;
    logic              advance;
    logic              step_en;

    assign advance      = !out_valid_reg || out_ch.ready;
    assign step_en      = in_valid_reg && advance;
    assign in_ch.ready  = !in_valid_reg || advance;

    atwc_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .item      (item_reg),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
                in_valid_reg <= in_ch.valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg.operation  <= in_ch.operation;
            item_reg.reg_offset <= in_ch.reg_offset;
            item_reg.write_data <= in_ch.write_data;
        end
        if (step_en)
            result_reg <= result_next;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.read_data = result_reg.read_data;
    assign out_ch.irq_raise = result_reg.irq_raise;

endmodule

// ----- sv/atwc_core.sv -----
module atwc_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step_en,
    input  atwc_pkg::item_t                   item,
    input  logic                              cfg_we,
    input  logic [atwc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [atwc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output atwc_pkg::result_t                 result
);

    localparam int W  = atwc_pkg::COUNTER_WIDTH;
    localparam int DW = atwc_pkg::DATA_W;

    logic                              family_reg;
    logic [atwc_pkg::SLOT_W-1:0]       slot_reg;

    logic [DW-1:0] cr1_reg,  cr1_next;
    logic [DW-1:0] cr2_reg,  cr2_next;
    logic [DW-1:0] smcr_reg, smcr_next;
    logic [DW-1:0] dier_reg, dier_next;
    logic [DW-1:0] sr_reg,   sr_next;
    logic [DW-1:0] ccmr_reg     [2];
    logic [DW-1:0] ccmr_next    [2];
    logic [DW-1:0] ccmr_act_reg [2];
    logic [DW-1:0] ccmr_act_next[2];
    logic [DW-1:0] ccer_reg,     ccer_next;
    logic [DW-1:0] ccer_act_reg, ccer_act_next;
    atwc_pkg::cnt_t cnt_reg, cnt_next;
    logic [atwc_pkg::PSC_W-1:0]     psc_reg, psc_next;
    logic [atwc_pkg::PSC_CNT_W-1:0] psc_cnt_reg, psc_cnt_next;
    atwc_pkg::cnt_t arr_reg, arr_next;
    logic [DW-1:0] rcr_reg, rcr_next;
    logic [atwc_pkg::REP_W-1:0] rep_cnt_reg, rep_cnt_next;
    logic dir_reg, dir_next;
    atwc_pkg::cnt_t ccr_reg [atwc_pkg::CHANNELS];
    atwc_pkg::cnt_t ccr_next[atwc_pkg::CHANNELS];
    logic [DW-1:0] bdtr_reg, bdtr_next;

    logic [DW-1:0]  rd;
    logic [atwc_pkg::IRQ_W-1:0] irq;
    logic [DW-1:0]  flags;
    logic [W:0]     cnt_inc;
    atwc_pkg::cnt_t cnt_dec;
    logic [1:0]     mode;
    logic           was_up;
    logic           wrap;
    logic           do_match;
    logic           upd_evt;
    logic           preload;
    logic [atwc_pkg::OFS_W-1:0] ofs;
    logic [DW-1:0]  wd;

    assign ofs     = item.reg_offset;
    assign wd      = item.write_data;
    assign preload = cr2_reg[0];
    assign mode    = cr1_reg[6:5];
    assign cnt_inc = {1'b0, cnt_reg} + (W+1)'(1);
    assign cnt_dec = (cnt_reg != '0) ? cnt_reg - W'(1) : cnt_reg;

    always_comb
    begin
        cr1_next         = cr1_reg;
        cr2_next         = cr2_reg;
        smcr_next        = smcr_reg;
        dier_next        = dier_reg;
        sr_next          = sr_reg;
        ccmr_next        = ccmr_reg;
        ccmr_act_next    = ccmr_act_reg;
        ccer_next        = ccer_reg;
        ccer_act_next    = ccer_act_reg;
        cnt_next         = cnt_reg;
        psc_next         = psc_reg;
        psc_cnt_next     = psc_cnt_reg;
        arr_next         = arr_reg;
        rcr_next         = rcr_reg;
        rep_cnt_next     = rep_cnt_reg;
        dir_next         = dir_reg;
        ccr_next         = ccr_reg;
        bdtr_next        = bdtr_reg;
        rd               = '0;
        irq              = '0;
        flags            = sr_reg;
        was_up           = !dir_reg;
        wrap             = 1'b0;
        do_match         = 1'b0;
        upd_evt          = 1'b0;

        if (step_en)
        begin
            case (item.operation)
                atwc_pkg::OP_READ:
                begin
                    case (ofs)
                        atwc_pkg::OFS_CR1:   rd = cr1_reg;
                        atwc_pkg::OFS_CR2:   rd = cr2_reg;
                        atwc_pkg::OFS_SMCR:  rd = smcr_reg;
                        atwc_pkg::OFS_DIER:  rd = dier_reg;
                        atwc_pkg::OFS_SR:    rd = sr_reg;
                        atwc_pkg::OFS_CCMR0: rd = ccmr_reg[0];
                        atwc_pkg::OFS_CCMR1: rd = ccmr_reg[1];
                        atwc_pkg::OFS_CCER:  rd = ccer_reg;
                        atwc_pkg::OFS_CNT:   rd = DW'(cnt_reg);
                        atwc_pkg::OFS_PSC:   rd = DW'(psc_reg);
                        atwc_pkg::OFS_ARR:   rd = DW'(arr_reg);
                        atwc_pkg::OFS_RCR:   rd = rcr_reg;
                        atwc_pkg::OFS_BDTR:  rd = bdtr_reg;
                        default:
                        begin
                            for (int ch = 0; ch < atwc_pkg::CHANNELS; ch++)
                            begin
                                if (ofs == atwc_pkg::OFS_CCR0
                                        + atwc_pkg::OFS_W'(ch * atwc_pkg::CCR_STRIDE))
                                    rd = DW'(ccr_reg[ch]);
                            end
                        end
                    endcase
                end

                atwc_pkg::OP_WRITE:
                begin
                    case (ofs)
                        atwc_pkg::OFS_CR1:   cr1_next  = wd;
                        atwc_pkg::OFS_CR2:   cr2_next  = wd;
                        atwc_pkg::OFS_SMCR:  smcr_next = wd;
                        atwc_pkg::OFS_DIER:  dier_next = wd;
                        atwc_pkg::OFS_SR:    sr_next   = sr_reg & wd;
                        atwc_pkg::OFS_EGR:
                        begin
                            if (wd[0])
                            begin
                                cnt_next     = '0;
                                psc_cnt_next = '0;
                                dir_next     = 1'b0;
                                rep_cnt_next = rcr_reg[atwc_pkg::REP_W-1:0];
                                flags[atwc_pkg::FLAG_UPDATE] = 1'b1;
                            end
                            if (wd[atwc_pkg::FLAG_COM])
                            begin
                                ccmr_act_next = ccmr_reg;
                                ccer_act_next = ccer_reg;
                                flags[atwc_pkg::FLAG_COM] = 1'b1;
                            end
                            flags   = flags | (wd & atwc_pkg::CHAN_FLAG_MASK)
                                            | (wd & atwc_pkg::TRG_BRK_MASK);
                            sr_next = flags;
                        end
                        atwc_pkg::OFS_CCMR0:
                        begin
                            ccmr_next[0] = wd;
                            if (!preload)
                                ccmr_act_next[0] = wd;
                        end
                        atwc_pkg::OFS_CCMR1:
                        begin
                            ccmr_next[1] = wd;
                            if (!preload)
                                ccmr_act_next[1] = wd;
                        end
                        atwc_pkg::OFS_CCER:
                        begin
                            ccer_next = wd;
                            if (!preload)
                                ccer_act_next = wd;
                        end
                        atwc_pkg::OFS_CNT:   cnt_next  = wd[W-1:0];
                        atwc_pkg::OFS_PSC:   psc_next  = wd[atwc_pkg::PSC_W-1:0];
                        atwc_pkg::OFS_ARR:   arr_next  = wd[W-1:0];
                        atwc_pkg::OFS_RCR:   rcr_next  = wd;
                        atwc_pkg::OFS_BDTR:  bdtr_next = wd;
                        default:
                        begin
                            for (int ch = 0; ch < atwc_pkg::CHANNELS; ch++)
                            begin
                                if (ofs == atwc_pkg::OFS_CCR0
                                        + atwc_pkg::OFS_W'(ch * atwc_pkg::CCR_STRIDE))
                                    ccr_next[ch] = wd[W-1:0];
                            end
                        end
                    endcase
                end

                atwc_pkg::OP_TICK:
                begin
                    if (cr1_reg[0])
                    begin
                        if (psc_cnt_reg < {1'b0, psc_reg})
                            psc_cnt_next = psc_cnt_reg + atwc_pkg::PSC_CNT_W'(1);
                        else
                        begin
                            psc_cnt_next = '0;
                            // A zero reload value stalls the counter and raises nothing
                            if (arr_reg != '0)
                            begin
                                if (mode != 2'd0)
                                begin
                                    if (was_up)
                                    begin
                                        if (cnt_inc >= {1'b0, arr_reg})
                                        begin
                                            cnt_next = arr_reg;
                                            dir_next = 1'b1;
                                            wrap     = 1'b1;
                                        end
                                        else
                                            cnt_next = cnt_inc[W-1:0];
                                    end
                                    else
                                    begin
                                        cnt_next = cnt_dec;
                                        if (cnt_dec == '0)
                                        begin
                                            dir_next = 1'b0;
                                            wrap     = 1'b1;
                                        end
                                    end
                                    do_match = (mode == 2'd3)
                                            || (mode == 2'd1 && !was_up)
                                            || (mode == 2'd2 && was_up);
                                end
                                else
                                begin
                                    if (cnt_inc > {1'b0, arr_reg})
                                    begin
                                        cnt_next = '0;
                                        wrap     = 1'b1;
                                    end
                                    else
                                        cnt_next = cnt_inc[W-1:0];
                                    do_match = 1'b1;
                                end

                                if (do_match)
                                begin
                                    for (int ch = 0; ch < atwc_pkg::CHANNELS; ch++)
                                    begin
                                        if (cnt_next == ccr_reg[ch])
                                            flags[ch+1] = 1'b1;
                                    end
                                end

                                // Repetition counter gates the update event
                                if (wrap)
                                begin
                                    if (rep_cnt_reg == '0)
                                    begin
                                        rep_cnt_next = rcr_reg[atwc_pkg::REP_W-1:0];
                                        upd_evt      = 1'b1;
                                    end
                                    else
                                        rep_cnt_next = rep_cnt_reg - atwc_pkg::REP_W'(1);
                                end

                                if (upd_evt)
                                begin
                                    flags[atwc_pkg::FLAG_UPDATE] = 1'b1;
                                    if (cr2_reg[0] && cr2_reg[2])
                                    begin
                                        ccmr_act_next = ccmr_reg;
                                        ccer_act_next = ccer_reg;
                                        flags[atwc_pkg::FLAG_COM] = 1'b1;
                                    end
                                end

                                sr_next = flags;
                                irq     = atwc_pkg::irq_map(family_reg, slot_reg,
                                                            flags & dier_reg);
                            end
                        end
                    end
                end

                default:
                begin
                    rd  = '0;
                    irq = '0;
                end
            endcase
        end
    end

    assign result.read_data = rd;
    assign result.irq_raise = irq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            family_reg <= 1'b1;
            slot_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                atwc_pkg::CFG_CORE_FAMILY: family_reg <= cfg_data[0];
                atwc_pkg::CFG_TIMER_SLOT:  slot_reg   <= cfg_data[atwc_pkg::SLOT_W-1:0];
                default:                   slot_reg   <= slot_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr1_reg      <= '0;
            cr2_reg      <= '0;
            smcr_reg     <= '0;
            dier_reg     <= '0;
            sr_reg       <= '0;
            ccmr_reg     <= '{default: '0};
            ccmr_act_reg <= '{default: '0};
            ccer_reg     <= '0;
            ccer_act_reg <= '0;
            cnt_reg      <= '0;
            psc_reg      <= '0;
            psc_cnt_reg  <= '0;
            arr_reg      <= '0;
            rcr_reg      <= '0;
            rep_cnt_reg  <= '0;
            dir_reg      <= 1'b0;
            ccr_reg      <= '{default: '0};
            bdtr_reg     <= '0;
        end
        else
        begin
            cr1_reg      <= cr1_next;
            cr2_reg      <= cr2_next;
            smcr_reg     <= smcr_next;
            dier_reg     <= dier_next;
            sr_reg       <= sr_next;
            ccmr_reg     <= ccmr_next;
            ccmr_act_reg <= ccmr_act_next;
            ccer_reg     <= ccer_next;
            ccer_act_reg <= ccer_act_next;
            cnt_reg      <= cnt_next;
            psc_reg      <= psc_next;
            psc_cnt_reg  <= psc_cnt_next;
            arr_reg      <= arr_next;
            rcr_reg      <= rcr_next;
            rep_cnt_reg  <= rep_cnt_next;
            dir_reg      <= dir_next;
            ccr_reg      <= ccr_next;
            bdtr_reg     <= bdtr_next;
        end
    end

endmodule

// ----- sv/atwc_checker.sv -----
`include "advanced_timer_with_compare_top_assert.svh"

module atwc_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [atwc_pkg::DATA_W-1:0]     read_data,
    input logic [atwc_pkg::IRQ_W-1:0]      irq_raise
);

    // Hold a stalled result
    `ATWC_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(read_data) && $stable(irq_raise)), "stalled result changed")

    `ATWC_ASSERT(a_ready_low_on_stall, !in_ready |-> (out_valid && !out_ready), "input held off without an output stall")

    `ATWC_ASSERT(a_stall_keeps_ready_low, (!in_ready && !out_ready) |=> (!in_ready || out_ready), "input reopened while output still stalled")

    // A read never raises lines, a tick never returns data
    `ATWC_NEVER(a_read_and_irq, out_valid && (read_data != '0) && (irq_raise != '0), "result carries both read data and interrupt lines")

    logic unused_in_valid;
    assign unused_in_valid = in_valid;

endmodule

bind advanced_timer_with_compare_top atwc_checker u_atwc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .read_data (out_ch.read_data),
    .irq_raise (out_ch.irq_raise)
);

// ----- tb/tb_top.sv -----
module tb_top;
    import atwc_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE  = 2'd3;
    localparam int              PHASES    = 12;
    localparam int              PER_PHASE = 41;
    localparam int              LIMIT     = 300000;

    localparam logic [OFS_W-1:0] REG_MAP [18] = '{
        OFS_CR1, OFS_CR2, OFS_SMCR, OFS_DIER, OFS_SR, OFS_EGR,
        OFS_CCMR0, OFS_CCMR1, OFS_CCER, OFS_CNT, OFS_PSC, OFS_ARR, OFS_RCR,
        OFS_CCR0, OFS_CCR0 + OFS_W'(CCR_STRIDE), OFS_CCR0 + OFS_W'(2 * CCR_STRIDE),
        OFS_CCR0 + OFS_W'(3 * CCR_STRIDE), OFS_BDTR
    };

    // interrupt routing per phase, extremes included
    localparam logic PLAN_FAMILY [PHASES] = '{1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0};
    localparam logic [SLOT_W-1:0] PLAN_SLOT [PHASES] =
        '{0, 0, 1, 1, 3, 2, 4, 5, 7, 3, 5, 6};

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    atwc_in_if  in_ch();
    atwc_out_if out_ch();

    advanced_timer_with_compare_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predicted timer state
    logic              route_family = 1'b1;
    logic [SLOT_W-1:0] route_slot   = '0;
    logic [31:0]       cr1 = '0, cr2 = '0, smcr = '0, dier = '0, sr = '0;
    logic [31:0]       ccer = '0, ccer_act = '0, rcr = '0, bdtr = '0;
    logic [31:0]       ccmr [2]     = '{default: '0};
    logic [31:0]       ccmr_act [2] = '{default: '0};
    cnt_t              cnt = '0, arr = '0;
    cnt_t              ccr [CHANNELS] = '{default: '0};
    logic [PSC_W-1:0]     psc     = '0;
    logic [PSC_CNT_W-1:0] psc_cnt = '0;
    logic [REP_W-1:0]     rep_cnt = '0;
    logic                 down    = 1'b0;

    item_t   bus_ops [$];
    result_t awaited_results [$];
    item_t   seen_op;
    result_t got, want;
    int      issued       = 0;
    int      results_seen = 0;
    int      failures     = 0;
    int      cycles       = 0;
    logic    in_took      = 1'b0;
    logic    calm         = 1'b0;
    int      burst_left   = 0;
    int      gap_left     = 0;
    int      stall_left   = 0;
    item_t   op_now;

    function automatic void fire_com();
        ccmr_act[0] = ccmr[0];
        ccmr_act[1] = ccmr[1];
        ccer_act    = ccer;
        sr[FLAG_COM] = 1'b1;
    endfunction

    // repetition counter: an update passes only when it has run down
    function automatic logic rep_gate();
        if (rep_cnt == '0)
        begin
            rep_cnt = rcr[REP_W-1:0];
            return 1'b1;
        end
        rep_cnt = rep_cnt - 1'b1;
        return 1'b0;
    endfunction

    function automatic void scan_compares();
        for (int ch = 0; ch < CHANNELS; ch++)
            if (cnt == ccr[ch])
                sr[ch + 1] = 1'b1;
    endfunction

    function automatic result_t timer_step(item_t it);
        result_t     res;
        logic [31:0] v;
        logic [31:0] pend;
        logic [16:0] nxt;
        logic [1:0]  mode;
        logic        was_up;
        logic        upd;
        logic        stepped;
        int          ch;
        res     = '0;
        v       = it.write_data;
        upd     = 1'b0;
        stepped = 1'b0;
        ch      = -1;
        if (it.reg_offset >= OFS_CCR0 && it.reg_offset <= OFS_CCR0 + OFS_W'(3 * CCR_STRIDE)
            && it.reg_offset[1:0] == 2'b00)
            ch = int'(it.reg_offset - OFS_CCR0) / CCR_STRIDE;
        if (ch >= CHANNELS)
            ch = -1;
        case (it.operation)
            OP_READ:
            begin
                case (it.reg_offset)
                    OFS_CR1:   res.read_data = cr1;
                    OFS_CR2:   res.read_data = cr2;
                    OFS_SMCR:  res.read_data = smcr;
                    OFS_DIER:  res.read_data = dier;
                    OFS_SR:    res.read_data = sr;
                    OFS_CCMR0: res.read_data = ccmr[0];
                    OFS_CCMR1: res.read_data = ccmr[1];
                    OFS_CCER:  res.read_data = ccer;
                    OFS_CNT:   res.read_data = 32'(cnt);
                    OFS_PSC:   res.read_data = 32'(psc);
                    OFS_ARR:   res.read_data = 32'(arr);
                    OFS_RCR:   res.read_data = rcr;
                    OFS_BDTR:  res.read_data = bdtr;
                    default:
                        if (ch >= 0)
                            res.read_data = 32'(ccr[ch]);
                endcase
            end
            OP_WRITE:
            begin
                case (it.reg_offset)
                    OFS_CR1:  cr1  = v;
                    OFS_CR2:  cr2  = v;
                    OFS_SMCR: smcr = v;
                    OFS_DIER: dier = v;
                    OFS_SR:   sr   = sr & v;
                    OFS_EGR:
                    begin
                        if (v[0])
                        begin
                            cnt     = '0;
                            psc_cnt = '0;
                            down    = 1'b0;
                            rep_cnt = rcr[REP_W-1:0];
                            sr[FLAG_UPDATE] = 1'b1;
                        end
                        if (v[FLAG_COM])
                            fire_com();
                        sr = sr | (v & CHAN_FLAG_MASK) | (v & TRG_BRK_MASK);
                    end
                    OFS_CCMR0:
                    begin
                        ccmr[0] = v;
                        if (!cr2[0])
                            ccmr_act[0] = v;
                    end
                    OFS_CCMR1:
                    begin
                        ccmr[1] = v;
                        if (!cr2[0])
                            ccmr_act[1] = v;
                    end
                    OFS_CCER:
                    begin
                        ccer = v;
                        if (!cr2[0])
                            ccer_act = v;
                    end
                    OFS_CNT:  cnt  = cnt_t'(v);
                    OFS_PSC:  psc  = v[PSC_W-1:0];
                    OFS_ARR:  arr  = cnt_t'(v);
                    OFS_RCR:  rcr  = v;
                    OFS_BDTR: bdtr = v;
                    default:
                        if (ch >= 0)
                            ccr[ch] = cnt_t'(v);
                endcase
            end
            OP_TICK:
            begin
                if (cr1[0])
                begin
                    if (psc_cnt < PSC_CNT_W'(psc))
                        psc_cnt = psc_cnt + 1'b1;
                    else
                    begin
                        psc_cnt = '0;
                        if (arr != '0)
                        begin
                            stepped = 1'b1;
                            mode    = cr1[6:5];
                            nxt     = 17'(cnt) + 17'd1;
                            if (mode != 2'd0)
                            begin
                                was_up = !down;
                                if (was_up)
                                begin
                                    if (nxt >= 17'(arr))
                                    begin
                                        cnt  = arr;
                                        down = 1'b1;
                                        upd  = rep_gate();
                                    end
                                    else
                                        cnt = nxt[15:0];
                                end
                                else
                                begin
                                    if (cnt != '0)
                                        cnt = cnt - 1'b1;
                                    if (cnt == '0)
                                    begin
                                        down = 1'b0;
                                        upd  = rep_gate();
                                    end
                                end
                                // match on the down slope, the up slope or both
                                if (mode == 2'd3 || (mode == 2'd1 && !was_up)
                                    || (mode == 2'd2 && was_up))
                                    scan_compares();
                            end
                            else
                            begin
                                if (nxt > 17'(arr))
                                begin
                                    cnt = '0;
                                    upd = rep_gate();
                                end
                                else
                                    cnt = nxt[15:0];
                                scan_compares();
                            end
                        end
                    end
                end
                if (upd)
                begin
                    sr[FLAG_UPDATE] = 1'b1;
                    if (cr2[0] && cr2[2])
                        fire_com();
                end
                pend = sr & dier;
                if (stepped && pend != '0)
                begin
                    if (route_family)
                    begin
                        case (route_slot)
                            0:
                            begin
                                res.irq_raise[IRQ_HI_UPDATE] = pend[FLAG_UPDATE];
                                res.irq_raise[IRQ_HI_CC]     = |(pend & CC_GROUP_MASK);
                            end
                            1: res.irq_raise[IRQ_HI_SLOT1] = 1'b1;
                            3: res.irq_raise[IRQ_HI_SLOT3] = 1'b1;
                            4: res.irq_raise[IRQ_HI_SLOT4] = 1'b1;
                            default: ;
                        endcase
                    end
                    else
                    begin
                        case (route_slot)
                            0:
                            begin
                                res.irq_raise[IRQ_LO_UPDATE] = |(pend & UP_GROUP_MASK);
                                res.irq_raise[IRQ_LO_CC]     = |(pend & CC_GROUP_MASK);
                            end
                            1: res.irq_raise[IRQ_LO_SLOT1] = 1'b1;
                            5: res.irq_raise[IRQ_LO_SLOT5] = 1'b1;
                            2: res.irq_raise[IRQ_LO_SLOT2] = 1'b1;
                            default: ;
                        endcase
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void queue_op(logic [OP_W-1:0] op, logic [OFS_W-1:0] ofs,
                                     logic [DATA_W-1:0] data);
        item_t it;
        it.operation  = op;
        it.reg_offset = ofs;
        it.write_data = data;
        bus_ops.push_back(it);
    endfunction

    task automatic drain();
        while (bus_ops.size() != 0 || results_seen < issued)
            @(negedge clk);
    endtask

    task automatic set_irq_routing(logic fam, logic [SLOT_W-1:0] slot);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CORE_FAMILY;
        cfg_data  <= CFG_DATA_W'(fam);
        @(negedge clk);
        cfg_index <= CFG_TIMER_SLOT;
        cfg_data  <= slot;
        @(negedge clk);
        cfg_we <= 1'b0;
        route_family = fam;
        route_slot   = slot;
    endtask

    // sender: bursts of transfers separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_ch.valid || in_took)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end
                else if (bus_ops.size() > 0)
                begin
                    op_now = bus_ops.pop_front();
                    issued++;
                    in_ch.valid      <= 1'b1;
                    in_ch.operation  <= op_now.operation;
                    in_ch.reg_offset <= op_now.reg_offset;
                    in_ch.write_data <= op_now.write_data;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = calm ? 1000 : $urandom_range(1, 20);
                        gap_left   = calm ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: short random stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left != 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 7);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                got.read_data = out_ch.read_data;
                got.irq_raise = out_ch.irq_raise;
                if (awaited_results.size() == 0)
                begin
                    $error("result with no expectation: read_data %h irq_raise %h",
                           got.read_data, got.irq_raise);
                    failures++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.read_data !== want.read_data)
                    begin
                        $error("read_data: expected %h, got %h", want.read_data, got.read_data);
                        failures++;
                    end
                    if (got.irq_raise !== want.irq_raise)
                    begin
                        $error("irq_raise: expected %h, got %h", want.irq_raise, got.irq_raise);
                        failures++;
                    end
                end
            end
            in_took <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready)
            begin
                seen_op = {in_ch.operation, in_ch.reg_offset, in_ch.write_data};
                awaited_results.push_back(timer_step(seen_op));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        logic [OP_W-1:0]   op;
        logic [OFS_W-1:0]  ofs;
        logic [DATA_W-1:0] data;
        int                pick;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.operation  = '0;
        in_ch.reg_offset = '0;
        in_ch.write_data = '0;
        out_ch.ready     = 1'b0;

        // edge cases: unmapped and misaligned offsets, spare opcode,
        // counter at its top, prescaler overtaken, zero reload, forced events
        queue_op(OP_READ, OFS_CR1, '0);
        queue_op(OP_WRITE, OFS_DIER, '1);
        queue_op(OP_WRITE, OFS_PSC, 32'd1);
        queue_op(OP_WRITE, OFS_ARR, 32'hFFFF);
        queue_op(OP_WRITE, OFS_CNT, 32'hFFFF);
        queue_op(OP_WRITE, OFS_CCR0, 32'd0);
        queue_op(OP_WRITE, OFS_CCR0 + OFS_W'(3 * CCR_STRIDE), '1);
        queue_op(OP_READ, OFS_CCR0 + OFS_W'(3 * CCR_STRIDE), '0);
        queue_op(OP_WRITE, 10'h3FF, '1);
        queue_op(OP_READ, 10'h3FF, '0);
        queue_op(OP_READ, OFS_CCR0 + 10'd2, '0);
        queue_op(OP_READ, OFS_EGR, '0);
        queue_op(OP_SPARE, 10'h3FF, '1);
        queue_op(OP_WRITE, OFS_CR1, 32'd1);
        queue_op(OP_TICK, '0, '0);
        queue_op(OP_WRITE, OFS_PSC, 32'd0);
        queue_op(OP_TICK, '0, '0);
        queue_op(OP_WRITE, OFS_ARR, 32'd0);
        queue_op(OP_TICK, '0, '0);
        queue_op(OP_WRITE, OFS_EGR, '1);
        queue_op(OP_READ, OFS_SR, '0);
        queue_op(OP_WRITE, OFS_SR, '0);
        queue_op(OP_WRITE, OFS_ARR, 32'd2);
        queue_op(OP_WRITE, OFS_CR1, 32'h61);
        repeat (3)
            queue_op(OP_TICK, '0, '0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // hold the sender until every result is back, then reroute
            drain();
            set_irq_routing(PLAN_FAMILY[ph], PLAN_SLOT[ph]);
            calm = (ph % 4 == 3);
            queue_op(OP_WRITE, OFS_ARR, $urandom_range(1, 9));
            queue_op(OP_WRITE, OFS_PSC, $urandom_range(0, 2));
            queue_op(OP_WRITE, OFS_CR1, 32'(((ph % 4) << 5) | 1));
            for (int n = 0; n < PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 99);
                ofs  = REG_MAP[$urandom_range(0, 17)];
                data = $urandom();
                if (pick < 45)
                begin
                    op  = OP_TICK;
                    ofs = OFS_W'($urandom_range(0, 1023));
                end
                else if (pick < 65)
                    op = OP_READ;
                else if (pick < 95)
                begin
                    op = OP_WRITE;
                    case (ofs)
                        OFS_CR1:
                            data = {data[31:1], 1'($urandom_range(0, 7) != 0)};
                        OFS_CNT, OFS_ARR:
                            if ($urandom_range(0, 7) != 0)
                                data = $urandom_range(0, 12);
                        OFS_PSC, OFS_RCR:
                            if ($urandom_range(0, 7) != 0)
                                data = $urandom_range(0, 3);
                        OFS_EGR:
                            data = data & $urandom() & $urandom();
                        default:
                            if (ofs >= OFS_CCR0 && ofs < OFS_BDTR && $urandom_range(0, 3) != 0)
                                data = $urandom_range(0, 12);
                    endcase
                end
                else
                begin
                    op  = OP_W'($urandom_range(0, 3));
                    ofs = OFS_W'($urandom_range(0, 1023));
                end
                queue_op(op, ofs, data);
            end
        end

        drain();
        repeat (8) @(negedge clk);
        if (awaited_results.size() != 0)
        begin
            $error("%0d results never arrived", awaited_results.size());
            failures++;
        end
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/atwc_pkg.sv
sv/atwc_if.sv
sv/atwc_core.sv
sv/advanced_timer_with_compare_top.sv
sv/atwc_checker.sv
tb/tb_top.sv
